/* design/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, command and status codes and types for the tagged priority
// queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TAG_W    = 16;
	localparam int RANK_W   = 8;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_LIST   = 2'd3;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_POPPED   = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_REMOVED  = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;
	localparam logic [2:0] ST_LISTED   = 3'd7;

	typedef struct packed {
		logic              valid;
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
	} entry_t;

	typedef struct packed {
		logic              ins;
		logic              pop;
		logic              rem;
		logic              rot;
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
	} ctrl_t;

endpackage
`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: compares its entry against the command and takes
// its next entry from itself, a neighbour, the head or the new item.
// ----------------------------------------------------------------------------
module spq_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  spq_pkg::ctrl_t          ctl,
	input  spq_pkg::entry_t         prev,
	input  wire                     prev_ge,
	input  spq_pkg::entry_t         nxt,
	input  spq_pkg::entry_t         head,
	input  wire                     hit_in,
	input  wire [spq_pkg::RANK_W-1:0] rank_in,
	output spq_pkg::entry_t         q,
	output logic                    ge,
	output logic                    hit_out,
	output logic [spq_pkg::RANK_W-1:0] rank_out
);
	import spq_pkg::*;

	logic              valid_q;
	logic [TAG_W-1:0]  tag_q;
	logic [RANK_W-1:0] rank_q;
	logic              match;
	entry_t cur;
	entry_t d;
	entry_t fresh;

	assign cur      = '{valid: valid_q, tag: tag_q, rank: rank_q};
	assign q        = cur;
	assign match    = cur.valid && (cur.tag == ctl.tag);
	assign ge       = cur.valid && (cur.rank >= ctl.rank);
	assign hit_out  = hit_in | match;
	assign rank_out = match ? cur.rank : rank_in;
	assign fresh    = '{valid: 1'b1, tag: ctl.tag, rank: ctl.rank};

	always_comb begin
		d = cur;
		if (ctl.ins) begin
			if (!ge) begin
				d = prev_ge ? fresh : prev;
			end
		end else if (ctl.pop) begin
			d = nxt;
		end else if (ctl.rem) begin
			if (hit_in || match) begin
				d = nxt;
			end
		end else if (ctl.rot) begin
			if (cur.valid) begin
				d = nxt.valid ? nxt : head;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q  <= d.tag;
		rank_q <= d.rank;
	end

endmodule
`default_nettype wire

/* design/stable_priority_queue_with_tags.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_with_tags
// Bounded priority queue of tagged entries held in a row of shifting cells.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Insert, pop and
// remove each give one result, registered from the execute state; busy falls
// as it is shown, so a new command can be taken while it is shown. Each costs
// one compare in every cell and a shift of the cell row. List gives one
// result per held entry without gaps, as the row rotates one entry into the
// head cell per cycle. An empty list gives one empty result. Results are
// shown for one cycle with done high and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module stable_priority_queue_with_tags (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [1:0]                   cmd,
	input  wire  [spq_pkg::TAG_W-1:0]    tag,
	input  wire  [spq_pkg::RANK_W-1:0]   rank,
	output logic                         busy,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [spq_pkg::TAG_W-1:0]    out_tag,
	output logic [spq_pkg::RANK_W-1:0]   out_rank,
	output logic                         last
);
	import spq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [1:0]        cmd_q;
	logic [TAG_W-1:0]  tag_q;
	logic [RANK_W-1:0] rank_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;

	logic              done_q, done_d;
	logic [2:0]        status_q, status_d;
	logic [TAG_W-1:0]  out_tag_q, out_tag_d;
	logic [RANK_W-1:0] out_rank_q, out_rank_d;
	logic              last_q, last_d;

	ctrl_t             ctl;
	entry_t            cell_q [CAPACITY];
	entry_t            cell_next [CAPACITY];
	entry_t            cell_prev [CAPACITY];
	logic [CAPACITY-1:0] ge;
	logic [CAPACITY:0]   hit;
	logic [RANK_W-1:0] rank_chain [CAPACITY+1];
	logic              any_match;
	logic              full;
	logic              accept;

	assign accept    = start && (state_q == S_IDLE);
	assign any_match = hit[CAPACITY];
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign hit[0]        = 1'b0;
	assign rank_chain[0] = '0;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign cell_prev[i] = '0;
			end else begin : g_mid
				assign cell_prev[i] = cell_q[i-1];
			end
			if (i == CAPACITY - 1) begin : g_end
				assign cell_next[i] = '0;
			end else begin : g_body
				assign cell_next[i] = cell_q[i+1];
			end
			spq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.prev     (cell_prev[i]),
				.prev_ge  ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i-1]),
				.nxt      (cell_next[i]),
				.head     (cell_q[0]),
				.hit_in   (hit[i]),
				.rank_in  (rank_chain[i]),
				.q        (cell_q[i]),
				.ge       (ge[i]),
				.hit_out  (hit[i+1]),
				.rank_out (rank_chain[i+1])
			);
		end
	endgenerate

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		done_d     = 1'b0;
		status_d   = status_q;
		out_tag_d  = out_tag_q;
		out_rank_d = out_rank_q;
		last_d     = 1'b1;
		ctl        = '{ins: 1'b0, pop: 1'b0, rem: 1'b0, rot: 1'b0, tag: tag_q, rank: rank_q};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d    = S_IDLE;
				done_d     = 1'b1;
				out_tag_d  = tag_q;
				out_rank_d = rank_q;
				case (cmd_q)
					CMD_INSERT: begin
						if (any_match) begin
							status_d = ST_DUP;
						end else if (full) begin
							status_d = ST_FULL;
						end else begin
							status_d = ST_ADDED;
							ctl.ins  = 1'b1;
							count_d  = count_q + CNT_W'(1);
						end
					end
					CMD_POP: begin
						if (count_q == '0) begin
							status_d   = ST_EMPTY;
							out_tag_d  = '0;
							out_rank_d = '0;
						end else begin
							status_d   = ST_POPPED;
							out_tag_d  = cell_q[0].tag;
							out_rank_d = cell_q[0].rank;
							ctl.pop    = 1'b1;
							count_d    = count_q - CNT_W'(1);
						end
					end
					CMD_REMOVE: begin
						if (any_match) begin
							status_d   = ST_REMOVED;
							out_rank_d = rank_chain[CAPACITY];
							ctl.rem    = 1'b1;
							count_d    = count_q - CNT_W'(1);
						end else begin
							status_d   = ST_NOTFOUND;
							out_rank_d = '0;
						end
					end
					default: begin
						if (count_q == '0) begin
							status_d   = ST_EMPTY;
							out_tag_d  = '0;
							out_rank_d = '0;
						end else begin
							done_d  = 1'b0;
							state_d = S_LIST;
							idx_d   = '0;
						end
					end
				endcase
			end
			S_LIST: begin
				done_d     = 1'b1;
				status_d   = ST_LISTED;
				out_tag_d  = cell_q[0].tag;
				out_rank_d = cell_q[0].rank;
				ctl.rot    = 1'b1;
				last_d     = (idx_q == count_q - CNT_W'(1));
				if (last_d) begin
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			tag_q  <= tag;
			rank_q <= rank;
		end
		status_q   <= status_d;
		out_tag_q  <= out_tag_d;
		out_rank_q <= out_rank_d;
		last_q     <= last_d;
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign status   = status_q;
	assign out_tag  = out_tag_q;
	assign out_rank = out_rank_q;
	assign last     = last_q;

endmodule
`default_nettype wire

/* design/spq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on command and result timing of the priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        start,
	input wire                        busy,
	input wire                        done,
	input wire [2:0]                  status,
	input wire                        last
);
	import spq_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer taken without busy");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !done)
		else $error("result without a command at work");

	a_list_runs_on: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy && (status == ST_LISTED))
		else $error("non-final result outside a list");

	a_list_next: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("gap in list results");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy)
		else $error("busy after final result");

endmodule

bind stable_priority_queue_with_tags spq_checker u_spq_checker (.*);
`default_nettype wire

/* tb/stable_priority_queue_with_tags_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_with_tags_tb
// Self-checking bench for the tagged priority queue: a directed pass over the
// empty, tied-rank, duplicate and full cases, then random command streams with
// and without sender gaps, every result checked against a behavioural queue model.
// ----------------------------------------------------------------------------
module stable_priority_queue_with_tags_tb;

	import spq_pkg::*;

	localparam int WATCHDOG_LIMIT = 600;

	typedef struct packed {
		logic [2:0]        status;
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
		logic              last;
	} resp_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [1:0]        cmd;
	logic [TAG_W-1:0]  tag;
	logic [RANK_W-1:0] rank;
	logic              busy;
	logic              done;
	logic [2:0]        status;
	logic [TAG_W-1:0]  out_tag;
	logic [RANK_W-1:0] out_rank;
	logic              last;

	// behavioural copy of the queue, front at index 0
	logic [TAG_W-1:0]  held_tag [CAPACITY];
	logic [RANK_W-1:0] held_rank [CAPACITY];
	int                held_cnt;

	resp_t resp_due[$];
	resp_t want;
	int    xfer_cnt;
	int    result_cnt;
	int    fail_cnt;
	int    quiet_cyc;
	int    status_seen [8];
	bit    gaps_on;

	stable_priority_queue_with_tags u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.tag      (tag),
		.rank     (rank),
		.busy     (busy),
		.done     (done),
		.status   (status),
		.out_tag  (out_tag),
		.out_rank (out_rank),
		.last     (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic push_resp(input logic [2:0] s, input logic [TAG_W-1:0] t,
			input logic [RANK_W-1:0] r, input logic l);
		resp_t x;
		x.status = s;
		x.tag    = t;
		x.rank   = r;
		x.last   = l;
		resp_due.push_back(x);
		status_seen[s]++;
	endtask

	task automatic drop_entry(input int pos);
		int i;
		for (i = pos; i < held_cnt - 1; i++) begin
			held_tag[i]  = held_tag[i + 1];
			held_rank[i] = held_rank[i + 1];
		end
		held_cnt--;
	endtask

	task automatic queue_command(input logic [1:0] c, input logic [TAG_W-1:0] t,
			input logic [RANK_W-1:0] r);
		int i;
		int hit;
		int pos;
		hit = -1;
		for (i = 0; i < held_cnt; i++)
			if (held_tag[i] == t && hit < 0)
				hit = i;
		case (c)
			CMD_INSERT: begin
				if (hit >= 0) begin
					push_resp(ST_DUP, t, r, 1'b1);
				end else if (held_cnt >= CAPACITY) begin
					push_resp(ST_FULL, t, r, 1'b1);
				end else begin
					pos = 0;
					while (pos < held_cnt && held_rank[pos] >= r)
						pos++;
					for (i = held_cnt; i > pos; i--) begin
						held_tag[i]  = held_tag[i - 1];
						held_rank[i] = held_rank[i - 1];
					end
					held_tag[pos]  = t;
					held_rank[pos] = r;
					held_cnt++;
					push_resp(ST_ADDED, t, r, 1'b1);
				end
			end
			CMD_POP: begin
				if (held_cnt == 0) begin
					push_resp(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					push_resp(ST_POPPED, held_tag[0], held_rank[0], 1'b1);
					drop_entry(0);
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0) begin
					push_resp(ST_REMOVED, t, held_rank[hit], 1'b1);
					drop_entry(hit);
				end else begin
					push_resp(ST_NOTFOUND, t, '0, 1'b1);
				end
			end
			default: begin
				if (held_cnt == 0)
					push_resp(ST_EMPTY, '0, '0, 1'b1);
				for (i = 0; i < held_cnt; i++)
					push_resp(ST_LISTED, held_tag[i], held_rank[i], i == held_cnt - 1);
			end
		endcase
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
		end
	endtask

	// result checking, then prediction for the command transfer at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				result_cnt++;
				if (resp_due.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result, expected none, actual status %0d tag %0h",
						$time, status, out_tag);
				end else begin
					want = resp_due.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("out_tag", 32'(want.tag), 32'(out_tag));
					check_field("out_rank", 32'(want.rank), 32'(out_rank));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			if (start && !busy) begin
				queue_command(cmd, tag, rank);
				xfer_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cyc);
			$display("stable_priority_queue_with_tags_tb: FAIL");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_cmd(input logic [1:0] c, input logic [TAG_W-1:0] t,
			input logic [RANK_W-1:0] r);
		int taken;
		taken = xfer_cnt;
		if (gaps_on && $urandom_range(3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd   = c;
		tag   = t;
		rank  = r;
		start = 1'b1;
		do @(negedge clk); while (xfer_cnt == taken);
		start = 1'b0;
	endtask

	function automatic logic [TAG_W-1:0] pick_tag(input int held_pct);
		int k;
		if (held_cnt > 0 && $urandom_range(99) < held_pct)
			return held_tag[$urandom_range(held_cnt - 1)];
		k = $urandom_range(9);
		if (k < 2)
			return TAG_W'($urandom_range(31));
		if (k == 2)
			return {TAG_W{1'b1}} - TAG_W'($urandom_range(3));
		return TAG_W'($urandom_range(65535));
	endfunction

	function automatic logic [RANK_W-1:0] pick_rank();
		int k;
		k = $urandom_range(9);
		if (k < 5)
			return RANK_W'($urandom_range(3));
		if (k == 5)
			return '0;
		if (k == 6)
			return {RANK_W{1'b1}};
		return RANK_W'($urandom_range(255));
	endfunction

	task automatic send_random(input int ins_w, input int pop_w, input int rem_w,
			input int list_w);
		int roll;
		roll = $urandom_range(ins_w + pop_w + rem_w + list_w - 1);
		if (roll < ins_w)
			send_cmd(CMD_INSERT, pick_tag(20), pick_rank());
		else if (roll < ins_w + pop_w)
			send_cmd(CMD_POP, TAG_W'($urandom_range(65535)), RANK_W'($urandom_range(255)));
		else if (roll < ins_w + pop_w + rem_w)
			send_cmd(CMD_REMOVE, pick_tag(60), RANK_W'($urandom_range(255)));
		else
			send_cmd(CMD_LIST, TAG_W'($urandom_range(65535)), RANK_W'($urandom_range(255)));
	endtask

	task automatic test_empty_queue();
		send_cmd(CMD_POP, 16'hFFFF, 8'hFF);
		send_cmd(CMD_LIST, 16'h1234, 8'h56);
		send_cmd(CMD_REMOVE, 16'h0000, 8'hFF);
	endtask

	task automatic test_order_and_keys();
		send_cmd(CMD_INSERT, 16'h0000, 8'h00);
		send_cmd(CMD_INSERT, 16'hFFFF, 8'hFF);
		send_cmd(CMD_INSERT, 16'h0000, 8'h80);
		send_cmd(CMD_INSERT, 16'h0005, 8'h00);
		send_cmd(CMD_LIST, 16'h0000, 8'h00);
		send_cmd(CMD_REMOVE, 16'hFFFF, 8'h00);
		send_cmd(CMD_REMOVE, 16'h1234, 8'h00);
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < CAPACITY - 2; i++)
			send_cmd(CMD_INSERT, TAG_W'(16'h0100 + i), (i % 3 == 0) ? 8'd7 : 8'(i * 17));
		send_cmd(CMD_INSERT, 16'hBEEF, 8'hFF);
		send_cmd(CMD_INSERT, 16'h0005, 8'h01);
		send_cmd(CMD_LIST, 16'hAAAA, 8'h55);
	endtask

	task automatic test_random_mixed();
		repeat (150)
			send_random(40, 20, 25, 15);
	endtask

	task automatic test_fill_and_drain();
		repeat (2) begin
			repeat (22)
				send_random(80, 5, 10, 5);
			repeat (18)
				send_random(10, 50, 35, 5);
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		repeat (60)
			send_random(40, 20, 25, 15);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = CMD_INSERT;
		tag        = '0;
		rank       = '0;
		held_cnt   = 0;
		xfer_cnt   = 0;
		result_cnt = 0;
		fail_cnt   = 0;
		quiet_cyc  = 0;
		gaps_on    = 1'b1;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_order_and_keys();
		test_full_queue();
		test_random_mixed();
		test_fill_and_drain();
		test_back_to_back();

		while (resp_due.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (resp_due.size() != 0) begin
			fail_cnt++;
			$display("%0t: %0d results never arrived", $time, resp_due.size());
		end

		$display("ran %0d commands, checked %0d results, %0d mismatches",
			xfer_cnt, result_cnt, fail_cnt);
		$display("added %0d dup %0d full %0d popped %0d empty %0d removed %0d missed %0d listed %0d",
			status_seen[ST_ADDED], status_seen[ST_DUP], status_seen[ST_FULL],
			status_seen[ST_POPPED], status_seen[ST_EMPTY], status_seen[ST_REMOVED],
			status_seen[ST_NOTFOUND], status_seen[ST_LISTED]);
		if (fail_cnt == 0)
			$display("stable_priority_queue_with_tags_tb: PASS");
		else
			$display("stable_priority_queue_with_tags_tb: FAIL");
		$finish;
	end

endmodule
